[rtl/core/edlc_pkg.sv]
// Shared types and constants for the eight-direction link cost block.
// Used by the front end, the item queue, the back end and the top level.
package edlc_pkg;

    typedef logic [23:0] t_pix;

    // One classified window, ready for the magnitude/cost engine
    typedef struct packed {
        t_pix [8:0]  win;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
        logic        clr;
    } t_item;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_RATIO  = 3'd3;
    localparam logic [2:0] CFG_MAXMAG = 3'd4;

    // sqrt(2) in Q1.16
    localparam logic [16:0] SQRT2_Q16 = 17'd92682;
    // ceil(2^21 / 3): exact divide by three for 20-bit values
    localparam logic [19:0] RECIP3 = 20'd699051;

    // floor(r * K / 3) for the remainder r of a divide by three,
    // K = 32768 on diagonal links and 4096 on axial links
    function automatic logic [14:0] rem_frac(input logic diag, input logic [1:0] r);
        logic [14:0] v;
        v = '0;
        case (r)
            2'd1:    v = diag ? 15'd10922 : 15'd1365;
            2'd2:    v = diag ? 15'd21845 : 15'd2730;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/edlc_front.sv]
// Front end: pixel intake, raster counters, two-row line store and 3x3 window.
// Depends on edlc_pkg; pushes one t_item per interior centre into the queue.
module edlc_front
    import edlc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [10:0] i_image_width,
    input  logic [12:0] i_image_height,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    logic [CW-1:0] w;
    logic [RW-1:0] h;

    logic          r_busy;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_clrp;
    t_pix [8:0]    r_win;
    logic [CW-1:0] r_pcol;
    logic [RW-1:0] r_prow;
    t_pix          r_px;
    logic [47:0]   r_rd;
    logic [47:0]   mem [MAX_WIDTH];

    logic          acc;
    logic          wrap_c;
    logic [CW-1:0] col_w;
    logic [RW-1:0] row_a;
    logic          clr_a;
    logic [RW-1:0] row_w;

    t_pix [8:0]    n_win;
    logic          interior;
    logic [CW-1:0] col_n;
    logic [RW-1:0] row_n;
    logic          eor;
    logic          end_clr;
    logic [31:0]   row_m1;
    logic [31:0]   col_m1;

    // Clamp frame size to the supported range
    always_comb begin
        if (i_image_width < 11'd3) begin
            w = CW'(3);
        end else if (32'(i_image_width) > MAX_WIDTH) begin
            w = CW'(MAX_WIDTH);
        end else begin
            w = CW'(i_image_width);
        end
        if (i_image_height < 13'd3) begin
            h = RW'(3);
        end else if (32'(i_image_height) > MAX_HEIGHT) begin
            h = RW'(MAX_HEIGHT);
        end else begin
            h = RW'(i_image_height);
        end
    end

    // Take a word only when the previous pixel is retired and the queue has room
    assign o_stall = r_busy || i_q_full;
    assign acc     = i_valid && !o_stall;

    // Wrap counters left behind by a shrunk frame size
    always_comb begin
        wrap_c = (r_col >= w);
        col_w  = wrap_c ? '0 : r_col;
        row_a  = wrap_c ? RW'(r_row + 1'b1) : r_row;
        clr_a  = (row_a >= h);
        row_w  = clr_a ? '0 : row_a;
    end

    // While busy: shift window and classify
    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = r_rd[47:24];
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = r_rd[23:0];
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_px;
        interior = (r_prow >= RW'(2)) && (r_pcol >= CW'(2));
        col_n    = CW'(r_pcol + 1'b1);
        row_n    = RW'(r_prow + 1'b1);
        eor      = (col_n >= w);
        end_clr  = eor && (row_n >= h);
        row_m1   = 32'(r_prow) - 32'd1;
        col_m1   = 32'(r_pcol) - 32'd1;
    end

    assign o_push      = r_busy && interior;
    assign o_item.win  = n_win;
    assign o_item.row  = row_m1[11:0];
    assign o_item.col  = col_m1[9:0];
    assign o_item.last = (row_n == h) && (col_n == w);
    assign o_item.clr  = r_clrp;

    // Line store: read on accept, write back the shifted column while busy
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd <= mem[col_w[AW-1:0]];
        end
        if (r_busy) begin
            mem[r_pcol[AW-1:0]] <= {r_rd[23:0], r_px};
        end
    end

    // Hold pixel and position for the window shift and classify step
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_pcol <= col_w;
            r_prow <= row_w;
            r_px   <= {i_red, i_green, i_blue};
        end
    end

    // Advance counters and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_col  <= '0;
            r_row  <= '0;
            r_clrp <= 1'b0;
            r_win  <= '0;
        end else if (acc) begin
            r_busy <= 1'b1;
            if (clr_a) begin
                r_clrp <= 1'b1;
            end
        end else if (r_busy) begin
            r_busy <= 1'b0;
            r_win  <= n_win;
            if (eor) begin
                r_col <= '0;
                r_row <= end_clr ? '0 : row_n;
            end else begin
                r_col <= col_n;
                r_row <= r_prow;
            end
            r_clrp <= o_push ? end_clr : (r_clrp || end_clr);
        end
    end

endmodule

[rtl/core/edlc_queue.sv]
// Two-entry queue of classified windows between front and back end.
// Depends on edlc_pkg for t_item.
module edlc_queue
    import edlc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

[rtl/core/edlc_back.sv]
// Back end: per-link channel sums, divide by three, bit-serial square root,
// cost weighting, running frame maximum and output register. Uses edlc_pkg.
module edlc_back
    import edlc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_item             i_item,
    input  logic              i_empty,
    output logic              o_pop,
    input  logic              i_mode,
    input  logic [11:0]       i_ratio,
    input  logic [15:0]       i_maxmag,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [11:0]       o_row,
    output logic [9:0]        o_col,
    output logic [7:0][23:0]  o_links,
    output logic              o_last,
    output logic [15:0]       o_fmax
);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_SUM   = 3'd1;
    localparam logic [2:0] B_DIV   = 3'd2;
    localparam logic [2:0] B_SQRT  = 3'd3;
    localparam logic [2:0] B_COST1 = 3'd4;
    localparam logic [2:0] B_COST2 = 3'd5;
    localparam logic [2:0] B_OUT   = 3'd6;

    logic [2:0]       r_state;
    logic [2:0]       r_k;
    logic [3:0]       r_cnt;
    t_item            r_item;
    logic [19:0]      r_s;
    logic [31:0]      r_x;
    logic [17:0]      r_rem;
    logic [15:0]      r_root;
    logic [27:0]      r_p;
    logic [7:0][23:0] r_link;
    logic [15:0]      r_rmax;

    logic             diag;
    t_pix             pa, pb, pc, pd;
    logic signed [10:0] dif [3];
    logic [9:0]       ab [3];
    logic [19:0]      sq [3];
    logic [19:0]      s_sum;

    logic [39:0]      q_prod;
    logic [18:0]      q3;
    logic [19:0]      three_q;
    logic [19:0]      r3w;
    logic [33:0]      x_new;

    logic [18:0]      rem2;
    logic [18:0]      trial;
    logic             ge;
    logic [18:0]      rem_n;

    logic [15:0]      cdiff;
    logic [44:0]      odd_prod;
    logic [23:0]      v;

    assign diag = r_k[0];

    // Select the window taps of the current link
    always_comb begin
        pa = '0;
        pb = '0;
        pc = '0;
        pd = '0;
        case (r_k)
            3'd0: begin pa = r_item.win[3]; pb = r_item.win[6];
                        pc = r_item.win[5]; pd = r_item.win[8]; end
            3'd1: begin pa = r_item.win[7]; pc = r_item.win[3]; end
            3'd2: begin pa = r_item.win[0]; pb = r_item.win[1];
                        pc = r_item.win[6]; pd = r_item.win[7]; end
            3'd3: begin pa = r_item.win[1]; pc = r_item.win[3]; end
            3'd4: begin pa = r_item.win[2]; pb = r_item.win[5];
                        pc = r_item.win[0]; pd = r_item.win[3]; end
            3'd5: begin pa = r_item.win[5]; pc = r_item.win[1]; end
            3'd6: begin pa = r_item.win[7]; pb = r_item.win[8];
                        pc = r_item.win[1]; pd = r_item.win[2]; end
            3'd7: begin pa = r_item.win[7]; pc = r_item.win[5]; end
            default: begin pa = '0; end
        endcase
    end

    // Sum of squared channel differences
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            dif[ch] = $signed({3'b000, pa[8*ch +: 8]}) + $signed({3'b000, pb[8*ch +: 8]})
                    - $signed({3'b000, pc[8*ch +: 8]}) - $signed({3'b000, pd[8*ch +: 8]});
            ab[ch]  = dif[ch][10] ? 10'(-dif[ch]) : dif[ch][9:0];
            sq[ch]  = {10'b0, ab[ch]} * {10'b0, ab[ch]};
        end
        s_sum = sq[0] + sq[1] + sq[2];
    end

    // Scale by 4096/3 or 32768/3 through a reciprocal divide
    always_comb begin
        q_prod  = {20'b0, r_s} * {20'b0, RECIP3};
        q3      = q_prod[39:21];
        three_q = {1'b0, q3} + {q3, 1'b0};
        r3w     = r_s - three_q;
        x_new   = (diag ? {q3, 15'b0} : {3'b000, q3, 12'b0})
                + {19'b0, rem_frac(diag, r3w[1:0])};
    end

    // One root bit per cycle
    always_comb begin
        rem2  = {r_rem[16:0], r_x[31:30]};
        trial = {1'b0, r_root, 2'b01};
        ge    = (rem2 >= trial);
        rem_n = ge ? (rem2 - trial) : rem2;
    end

    // Cost weighting
    always_comb begin
        cdiff    = (i_maxmag > r_root) ? (i_maxmag - r_root) : '0;
        odd_prod = {17'b0, r_p} * {28'b0, SQRT2_Q16};
        if (!i_mode) begin
            v = {8'b0, r_root};
        end else if (r_k[0]) begin
            v = {3'b000, odd_prod[44:24]};
        end else begin
            v = {4'b0000, r_p[27:8]};
        end
    end

    assign o_pop   = (r_state == B_IDLE) && !i_empty;
    assign o_valid = (r_state == B_OUT);
    assign o_row   = r_item.row;
    assign o_col   = r_item.col;
    assign o_last  = r_item.last;
    assign o_links = r_link;
    assign o_fmax  = r_rmax;

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    r_item <= i_item;
                end
            end
            B_SUM: begin
                r_s <= s_sum;
            end
            B_DIV: begin
                r_x    <= x_new[31:0];
                r_rem  <= '0;
                r_root <= '0;
            end
            B_SQRT: begin
                r_x    <= {r_x[29:0], 2'b00};
                r_rem  <= rem_n[17:0];
                r_root <= {r_root[14:0], ge};
            end
            B_COST1: begin
                r_p <= {12'b0, cdiff} * {16'b0, i_ratio};
            end
            B_COST2: begin
                r_link[r_k] <= v;
            end
            default: begin
                r_s <= r_s;
            end
        endcase
    end

    // Sequence the eight links of one item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_k     <= '0;
            r_cnt   <= '0;
            r_rmax  <= '0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_k     <= '0;
                        r_state <= B_SUM;
                        if (i_item.clr) begin
                            r_rmax <= '0;
                        end
                    end
                end
                B_SUM: begin
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_cnt   <= '0;
                    r_state <= B_SQRT;
                end
                B_SQRT: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= B_COST1;
                    end
                end
                B_COST1: begin
                    if (r_root > r_rmax) begin
                        r_rmax <= r_root;
                    end
                    r_state <= B_COST2;
                end
                B_COST2: begin
                    r_k <= r_k + 3'd1;
                    r_state <= (r_k == 3'd7) ? B_OUT : B_SUM;
                end
                B_OUT: begin
                    if (!i_stall) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/eight_direction_link_cost.sv]
// Top level of the eight-direction link cost block: configuration registers,
// front end, item queue and back end. Depends on edlc_pkg and the edlc_* modules.
//
//   channel   direction  handshake          payload
//   pixel     in         i_valid/o_stall    i_red, i_green, i_blue
//   result    out        o_valid/i_stall    o_center_row .. o_frame_max
//   config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// The front end takes a new pixel only once the last is retired (line store read,
// then write back). The back end loads an item, runs each of its eight links through
// sum, divide, a 16-step square root and two cost steps, then hands the result off.
// Synchronous active-low reset clears counters, queue and running maximum;
// the line store is not cleared. A stalled result holds in the output register
// while the front end keeps filling the two-entry queue.
module eight_direction_link_cost
    import edlc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_center_row,
    output logic [9:0]  o_center_col,
    output logic [23:0] o_link_right,
    output logic [23:0] o_link_diag_one,
    output logic [23:0] o_link_up,
    output logic [23:0] o_link_diag_three,
    output logic [23:0] o_link_left,
    output logic [23:0] o_link_diag_five,
    output logic [23:0] o_link_down,
    output logic [23:0] o_link_diag_seven,
    output logic        o_frame_last,
    output logic [15:0] o_frame_max
);

    logic        r_mode;
    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [11:0] r_ratio;
    logic [15:0] r_maxmag;

    logic             q_push;
    t_item            q_in;
    logic             q_pop;
    t_item            q_out;
    logic             q_full;
    logic             q_empty;
    logic [7:0][23:0] links;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_width  <= 11'd640;
            r_height <= 13'd480;
            r_ratio  <= 12'd256;
            r_maxmag <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:   r_mode   <= i_cfg_data[0];
                CFG_WIDTH:  r_width  <= i_cfg_data[10:0];
                CFG_HEIGHT: r_height <= i_cfg_data[12:0];
                CFG_RATIO:  r_ratio  <= i_cfg_data[11:0];
                CFG_MAXMAG: r_maxmag <= i_cfg_data;
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    edlc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_image_width  (r_width),
        .i_image_height (r_height),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_item         (q_in)
    );

    edlc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    edlc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (q_out),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .i_mode   (r_mode),
        .i_ratio  (r_ratio),
        .i_maxmag (r_maxmag),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_row    (o_center_row),
        .o_col    (o_center_col),
        .o_links  (links),
        .o_last   (o_frame_last),
        .o_fmax   (o_frame_max)
    );

    assign o_link_right      = links[0];
    assign o_link_diag_one   = links[1];
    assign o_link_up         = links[2];
    assign o_link_diag_three = links[3];
    assign o_link_left       = links[4];
    assign o_link_diag_five  = links[5];
    assign o_link_down       = links[6];
    assign o_link_diag_seven = links[7];

endmodule

[bench/eight_direction_link_cost_test.sv]
// Self-checking bench for eight_direction_link_cost: random RGB frames, a local
// link cost predictor and a checker of each result word. Depends on edlc_pkg and the RTL.
module eight_direction_link_cost_test
    import edlc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_MAX_W = 1024;
    localparam int TB_MAX_H = 4096;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_pixel;

    typedef struct packed {
        logic [11:0]      row;
        logic [9:0]       col;
        logic [7:0][23:0] link;
        logic             last;
        logic [15:0]      fmax;
    } t_link_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_red = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_blue = '0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = CFG_MODE;
    logic [15:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [11:0] o_center_row;
    logic [9:0]  o_center_col;
    logic [23:0] o_link_right, o_link_diag_one, o_link_up, o_link_diag_three;
    logic [23:0] o_link_left, o_link_diag_five, o_link_down, o_link_diag_seven;
    logic        o_frame_last;
    logic [15:0] o_frame_max;

    eight_direction_link_cost u_top (.*);

    always #4 i_clk = ~i_clk;

    // Pixel source and expected link words
    t_pixel     pixel_q[$];
    t_link_word cost_q[$];

    // Predictor state and shadow registers
    logic [47:0] pr_line[TB_MAX_W];
    logic [23:0] pr_win[9];
    int unsigned pr_row, pr_col, pr_max, pr_last_max;
    int unsigned sh_mode = 0, sh_width = 640, sh_height = 480, sh_ratio = 256, sh_maxmag = 0;

    int unsigned n_pixels, n_words, n_frames, n_errors;
    bit quiet, hold_req, hold_done;
    int unsigned send_gap, stall_burst, hold_cnt;
    logic next_valid, next_stall;
    t_pixel next_pix;
    t_link_word got, exp_w;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [31:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res, one, rem;
        res = 0;
        rem = x;
        one = 64'd1 << 62;
        while (one > rem) one = one >> 2;
        while (one != 0) begin
            if (rem >= res + one) begin
                rem = rem - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res[31:0];
    endfunction

    function automatic int chan(input logic [23:0] px, input int k);
        return int'(px[23 - 8 * k -: 8]);
    endfunction

    // RMS gradient of one link in Q8.8; diagonal links use taps a and c only
    function automatic logic [31:0] grad_mag(input int a, input int b, input int c, input int d,
                                             input bit diag);
        logic [63:0] s;
        int dv;
        s = 0;
        for (int k = 0; k < 3; k++) begin
            if (diag) dv = chan(pr_win[a], k) - chan(pr_win[c], k);
            else dv = chan(pr_win[a], k) + chan(pr_win[b], k)
                      - chan(pr_win[c], k) - chan(pr_win[d], k);
            s += 64'(dv * dv);
        end
        return int_sqrt(diag ? (s * 32768) / 3 : (s * 4096) / 3);
    endfunction

    // Advance the predictor by one pixel; queue a link word for interior centres
    function automatic void predict_pixel(input t_pixel p);
        int unsigned w, h, row, col;
        logic [23:0] px, top, mid;
        logic [31:0] mag[8];
        logic [63:0] c, v;
        t_link_word lw;
        w = clamp_dim(sh_width, TB_MAX_W);
        h = clamp_dim(sh_height, TB_MAX_H);
        if (pr_col >= w) begin
            pr_col = 0;
            pr_row++;
        end
        if (pr_row >= h) begin
            pr_row = 0;
            pr_max = 0;
        end
        row = pr_row;
        col = pr_col;
        px = {p.r, p.g, p.b};
        top = pr_line[col][47:24];
        mid = pr_line[col][23:0];
        pr_line[col] = {mid, px};
        for (int r = 0; r < 3; r++) begin
            pr_win[r * 3] = pr_win[r * 3 + 1];
            pr_win[r * 3 + 1] = pr_win[r * 3 + 2];
        end
        pr_win[2] = top;
        pr_win[5] = mid;
        pr_win[8] = px;
        if (row >= 2 && col >= 2) begin
            mag[0] = grad_mag(3, 6, 5, 8, 0);
            mag[2] = grad_mag(0, 1, 6, 7, 0);
            mag[4] = grad_mag(2, 5, 0, 3, 0);
            mag[6] = grad_mag(7, 8, 1, 2, 0);
            mag[1] = grad_mag(7, 0, 3, 0, 1);
            mag[3] = grad_mag(1, 0, 3, 0, 1);
            mag[5] = grad_mag(5, 0, 1, 0, 1);
            mag[7] = grad_mag(7, 0, 5, 0, 1);
            lw.row = 12'(row - 1);
            lw.col = 10'(col - 1);
            for (int k = 0; k < 8; k++) begin
                if (mag[k] > pr_max) pr_max = mag[k];
                if (sh_mode == 0) begin
                    v = mag[k];
                end else begin
                    c = (sh_maxmag > mag[k]) ? 64'(sh_maxmag - mag[k]) : 64'd0;
                    if (k % 2 == 0) v = (c * sh_ratio) >> 8;
                    else v = (c * sh_ratio * 64'(SQRT2_Q16)) >> 24;
                end
                if (v > 64'hFF_FFFF) v = 64'hFF_FFFF;
                lw.link[k] = v[23:0];
            end
            lw.last = (row == h - 1 && col == w - 1);
            lw.fmax = pr_max[15:0];
            if (lw.last) pr_last_max = pr_max;
            cost_q.insert(cost_q.size(), lw);
        end
        pr_col = col + 1;
        if (pr_col >= w) begin
            pr_col = 0;
            pr_row = row + 1;
            if (pr_row >= h) begin
                pr_row = 0;
                pr_max = 0;
            end
        end
    endfunction

    // Drive pixels from the queue; hold a word until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            next_valid = i_valid;
            if (i_valid && !o_stall) begin
                predict_pixel('{i_red, i_green, i_blue});
                n_pixels++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pixel_q.size() > 0) begin
                    if (!quiet && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(1, 7);
                    end else begin
                        next_pix = pixel_q.pop_front();
                        i_red <= next_pix.r;
                        i_green <= next_pix.g;
                        i_blue <= next_pix.b;
                        next_valid = 1'b1;
                    end
                end
            end
            i_valid <= next_valid;
        end
    end

    // Check each accepted link word and pick the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_burst = 0;
            hold_cnt = 0;
        end else begin
            if (o_valid && !i_stall) begin
                got.row = o_center_row;
                got.col = o_center_col;
                got.link = {o_link_diag_seven, o_link_down, o_link_diag_five, o_link_left,
                            o_link_diag_three, o_link_up, o_link_diag_one, o_link_right};
                got.last = o_frame_last;
                got.fmax = o_frame_max;
                n_words++;
                if (got.last) n_frames++;
                if (cost_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected word row=%0d col=%0d", got.row, got.col);
                end else begin
                    exp_w = cost_q.pop_front();
                    if (got !== exp_w) begin
                        n_errors++;
                        if (n_errors <= 10) begin
                            $display("mismatch exp row=%0d col=%0d last=%0d max=%h links=%h",
                                     exp_w.row, exp_w.col, exp_w.last, exp_w.fmax, exp_w.link);
                            $display("         got row=%0d col=%0d last=%0d max=%h links=%h",
                                     got.row, got.col, got.last, got.fmax, got.link);
                        end
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_cnt = 3000;
                hold_done = 1;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                next_stall = 1'b1;
            end else if (quiet) begin
                next_stall = 1'b0;
            end else if (stall_burst > 0) begin
                stall_burst--;
                next_stall = 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_burst = $urandom_range(0, 6);
                next_stall = 1'b1;
            end else begin
                next_stall = 1'b0;
            end
            i_stall <= next_stall;
        end
    end

    task automatic wait_idle();
        while (pixel_q.size() != 0 || i_valid || cost_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 16'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:   sh_mode = val & 1;
            CFG_WIDTH:  sh_width = val & 11'h7FF;
            CFG_HEIGHT: sh_height = val & 13'h1FFF;
            CFG_RATIO:  sh_ratio = val & 12'hFFF;
            CFG_MAXMAG: sh_maxmag = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    // Pixel content: mostly random, sometimes hard extremes for large gradients
    task automatic add_pixels(input int unsigned n);
        bit ext;
        ext = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
            if (ext) pixel_q.insert(pixel_q.size(), {$urandom_range(0, 1) ? 8'hFF : 8'h00,
                                                     $urandom_range(0, 1) ? 8'hFF : 8'h00,
                                                     $urandom_range(0, 1) ? 8'hFF : 8'h00});
            else pixel_q.insert(pixel_q.size(), 24'($urandom));
        end
    endtask

    // Complete the current frame so a wider size can follow safely
    task automatic finish_frame();
        int unsigned w, h, row, col;
        w = clamp_dim(sh_width, TB_MAX_W);
        h = clamp_dim(sh_height, TB_MAX_H);
        row = pr_row;
        col = pr_col;
        // Apply the wrap a shrunk size causes on the next pixel
        if (col >= w) begin
            col = 0;
            row++;
        end
        if (row >= h) row = 0;
        if (row != 0 || col != 0) add_pixels((h - row) * w - col);
        wait_idle();
    endtask

    initial begin
        int unsigned w, h, target;
        for (int i = 0; i < TB_MAX_W; i++) pr_line[i] = '0;
        for (int i = 0; i < 9; i++) pr_win[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: smallest frame, checkerboard of full-scale pixels, both modes
        cfg_write(CFG_WIDTH, 3);
        cfg_write(CFG_HEIGHT, 3);
        cfg_write(CFG_RATIO, 4095);
        cfg_write(CFG_MAXMAG, 65535);
        cfg_write(CFG_MODE, 0);
        for (int i = 0; i < 9; i++)
            pixel_q.insert(pixel_q.size(), i % 2 ? 24'hFFFFFF : 24'h000000);
        wait_idle();
        cfg_write(CFG_MODE, 1);
        for (int i = 0; i < 9; i++)
            pixel_q.insert(pixel_q.size(), i % 3 ? 24'h00FF00 : 24'hFF00FF);
        pixel_q.insert(pixel_q.size(), 24'h000000);
        pixel_q.insert(pixel_q.size(), 24'hFFFFFF);
        wait_idle();
        // Undersized values clamp to three; zero ratio and zero maximum
        finish_frame();
        cfg_write(CFG_WIDTH, 0);
        cfg_write(CFG_HEIGHT, 1);
        cfg_write(CFG_RATIO, 0);
        cfg_write(CFG_MAXMAG, 0);
        add_pixels(9);
        wait_idle();

        // Oversized values clamp; then shrink the size in the middle of the frame
        cfg_write(CFG_WIDTH, 2047);
        cfg_write(CFG_HEIGHT, 8191);
        cfg_write(CFG_MODE, 0);
        add_pixels(20);
        wait_idle();
        cfg_write(CFG_WIDTH, 4);
        cfg_write(CFG_HEIGHT, 3);
        finish_frame();

        // Random frames; some take their maximum from the last finished frame, others a random one
        target = n_pixels + 460;
        while (n_pixels < target) begin
            w = $urandom_range(3, 8);
            h = $urandom_range(3, 6);
            cfg_write(CFG_WIDTH, w);
            cfg_write(CFG_HEIGHT, h);
            cfg_write(CFG_MODE, $urandom_range(0, 1));
            cfg_write(CFG_RATIO, $urandom_range(0, 3) == 0 ? 4095 : $urandom_range(0, 4095));
            cfg_write(CFG_MAXMAG, $urandom_range(0, 1) ? pr_last_max : $urandom_range(0, 65535));
            add_pixels(w * h * $urandom_range(1, 2));
            if ($urandom_range(0, 3) == 0) begin
                // Drop to a smaller frame partway through
                add_pixels($urandom_range(1, w * h - 1));
                wait_idle();
                cfg_write(CFG_WIDTH, $urandom_range(3, w));
                cfg_write(CFG_HEIGHT, $urandom_range(3, h));
            end
            finish_frame();
            if (n_pixels > target - 300 && !hold_done) begin
                // Long receiver hold while pixels keep coming
                cfg_write(CFG_WIDTH, 8);
                cfg_write(CFG_HEIGHT, 6);
                hold_req = 1;
                add_pixels(48);
                finish_frame();
            end
        end

        // Final stretch with no idling on either side
        quiet = 1;
        cfg_write(CFG_WIDTH, 5);
        cfg_write(CFG_HEIGHT, 4);
        cfg_write(CFG_MODE, 1);
        cfg_write(CFG_MAXMAG, 65535);
        add_pixels(40);
        wait_idle();

        $display("covered %0d pixels, %0d link words, %0d complete frames, both modes",
                 n_pixels, n_words, n_frames);
        $display("sizes from clamped minimum to oversized settings, mid-frame shrinks, long hold");
        if (n_errors == 0) begin
            $display("[eight_direction_link_cost] OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("[eight_direction_link_cost] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("timeout");
        $display("[eight_direction_link_cost] ERROR");
        $finish;
    end

endmodule
